FILE: src/ahc_pkg.sv
// Shared types and constants for the allocation history checker.
// No dependencies; every other file imports this package.
package ahc_pkg;

    // width of the address field on the ports
    localparam int FIELD_AW = 32;

    // event operation codes (code 3 is stored but matches nothing)
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_REALLOC = 2'd1;
    localparam logic [1:0] OP_FREE    = 2'd2;

    typedef enum logic [2:0] {
        W_LEAK                = 3'd0,
        W_DOUBLE_FREE         = 3'd1,
        W_WRONG_ALLOC         = 3'd2,
        W_REALLOC_UNREC       = 3'd3,
        W_REALLOC_NEVER_FREED = 3'd4,
        W_REALLOC_FREED       = 3'd5,
        W_ALLOC_LIVE          = 3'd6
    } warn_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED,
        ST_DEC,
        ST_EMIT
    } state_t;

    // one history entry, minus its address; na/nf/nr mark a newer alloc,
    // free or realloc of the same address somewhere in the history
    typedef struct packed {
        logic [1:0] op;
        logic       kind;
        logic       na;
        logic       nf;
        logic       nr;
    } entry_t;

    // per-cell match summary for the event under check
    typedef struct packed {
        logic alloc;   // this cell holds the newest alloc of the address
        logic free;    // this cell holds a free of the address
        logic a_nf;    // newest alloc has a newer free
        logic a_nr;    // newest alloc has a newer realloc
        logic a_kind;  // allocator kind of the newest alloc
    } hit_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic       cmp;    // capture match summary
        logic       shift;  // take neighbor's entry
        logic [1:0] op;     // operation of the event under check
        logic       kind;   // allocator kind of the event under check
    } cell_ctl_t;

    // one pending warning
    typedef struct packed {
        warn_t code;
        logic  fatal;
        logic  from_leak;
    } res_t;

endpackage

FILE: src/ahc_cell.sv
// One history cell: holds an entry, compares it against the event under
// check and hands it to the older neighbor on a shift. Uses ahc_pkg.
module ahc_cell #(
    parameter int AW = 32
) (
    input  logic              clk,
    input  ahc_pkg::cell_ctl_t ctl,
    input  logic [AW-1:0]     new_addr,
    input  logic              cell_valid,
    input  logic [AW-1:0]     prev_addr,
    input  ahc_pkg::entry_t   prev_entry,
    output logic [AW-1:0]     addr,
    output ahc_pkg::entry_t   entry,
    output ahc_pkg::entry_t   fwd_entry,
    output ahc_pkg::hit_t     hit
);
    import ahc_pkg::*;

    logic [AW-1:0] addr_reg;
    entry_t        entry_reg;
    hit_t          hit_reg;
    hit_t          hit_next;
    logic          match;
    logic          newest_alloc;

    assign match        = cell_valid && (addr_reg == new_addr);
    assign newest_alloc = match && (entry_reg.op == OP_ALLOC) && !entry_reg.na;

    always_comb
    begin
        hit_next.alloc  = newest_alloc;
        hit_next.free   = match && (entry_reg.op == OP_FREE);
        hit_next.a_nf   = newest_alloc && entry_reg.nf;
        hit_next.a_nr   = newest_alloc && entry_reg.nr;
        hit_next.a_kind = newest_alloc && entry_reg.kind;
    end

    // the new event becomes newer than this entry as it moves on
    always_comb
    begin
        fwd_entry    = entry_reg;
        fwd_entry.na = entry_reg.na | (match && (ctl.op == OP_ALLOC));
        fwd_entry.nf = entry_reg.nf | (match && (ctl.op == OP_FREE));
        fwd_entry.nr = entry_reg.nr | (match && (ctl.op == OP_REALLOC));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmp)
        begin
            hit_reg <= hit_next;
        end
        if (ctl.shift)
        begin
            addr_reg  <= prev_addr;
            entry_reg <= prev_entry;
        end
    end

    assign addr  = addr_reg;
    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

FILE: src/ahc_ctrl.sv
// Sequencer for the allocation history checker: handshakes, fill count,
// match reduction, rule decision and warning output. Uses ahc_pkg.
module ahc_ctrl #(
    parameter int AW = 32,
    parameter int N  = 63,
    parameter int CW = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ahc_pkg::FIELD_AW-1:0]   address,
    input  logic                           alloc_kind,
    input  logic [1:0]                     operation,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           check_enable,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     warning_code,
    output logic                           fatal,
    output logic [ahc_pkg::FIELD_AW-1:0]   entry_address,
    output logic                           last_result,
    output ahc_pkg::cell_ctl_t             ctl,
    output logic [AW-1:0]                  new_addr,
    output logic [CW-1:0]                  count,
    input  ahc_pkg::hit_t [N-1:0]          hits,
    input  ahc_pkg::entry_t                oldest_entry,
    input  logic [AW-1:0]                  oldest_addr
);
    import ahc_pkg::*;

    state_t        state_reg, state_next;
    logic [AW-1:0] addr_reg;
    logic          kind_reg;
    logic [1:0]    op_reg;
    logic          en_reg;
    logic          halted_reg, halted_next;
    logic [CW-1:0] count_reg, count_next;

    hit_t          sum_reg, sum_next;
    res_t          res_reg [3];
    res_t          res_next [3];
    logic [1:0]    res_cnt_reg, res_cnt_next;
    logic [1:0]    ptr_reg, ptr_next;
    logic [AW-1:0] leak_addr_reg;

    logic          out_valid_reg, out_valid_next;
    warn_t         out_code_reg;
    logic          out_fatal_reg;
    logic [AW-1:0] out_addr_reg;
    logic          out_last_reg;

    logic          accept;
    logic          full;
    logic          load_out;
    logic          any_fatal;
    logic          free_newer;
    logic          wrong_kind;
    res_t          cur_res;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg == CW'(N));

    assign ctl.cmp   = (state_reg == ST_CMP);
    assign ctl.shift = (state_reg == ST_DEC);
    assign ctl.op    = op_reg;
    assign ctl.kind  = kind_reg;
    assign new_addr  = addr_reg;
    assign count     = count_reg;

    // OR the per-cell match summaries
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < N; i++)
        begin
            sum_next = sum_next | hits[i];
        end
    end

    assign free_newer = sum_reg.free && (!sum_reg.alloc || sum_reg.a_nf);
    assign wrong_kind = sum_reg.alloc && (sum_reg.a_kind != kind_reg);

    // build the warning list for this event in rule order
    always_comb
    begin
        logic [1:0] n;
        logic       stop;
        n = 2'd0;
        stop = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            res_next[i] = '{code: W_LEAK, fatal: 1'b0, from_leak: 1'b0};
        end
        if (full && en_reg && (oldest_entry.op != OP_FREE) && !oldest_entry.nf)
        begin
            res_next[n] = '{code: W_LEAK, fatal: 1'b0, from_leak: 1'b1};
            n = n + 2'd1;
        end
        if (en_reg)
        begin
            if ((op_reg == OP_FREE) && free_newer)
            begin
                res_next[n] = '{code: W_DOUBLE_FREE, fatal: 1'b1, from_leak: 1'b0};
                n = n + 2'd1;
                stop = 1'b1;
            end
            if (!stop && ((op_reg == OP_FREE) || (op_reg == OP_REALLOC)) && wrong_kind)
            begin
                res_next[n] = '{code: W_WRONG_ALLOC, fatal: 1'b1, from_leak: 1'b0};
                n = n + 2'd1;
                stop = 1'b1;
            end
            if (!stop && (op_reg == OP_REALLOC) && !sum_reg.alloc)
            begin
                res_next[n] = '{code: W_REALLOC_UNREC, fatal: 1'b0, from_leak: 1'b0};
                n = n + 2'd1;
            end
            if (!stop && (op_reg == OP_REALLOC) && !sum_reg.alloc && !sum_reg.free)
            begin
                res_next[n] = '{code: W_REALLOC_NEVER_FREED, fatal: 1'b0,
                                from_leak: 1'b0};
                n = n + 2'd1;
            end
            if (!stop && (op_reg == OP_REALLOC) && free_newer)
            begin
                res_next[n] = '{code: W_REALLOC_FREED, fatal: 1'b1, from_leak: 1'b0};
                n = n + 2'd1;
                stop = 1'b1;
            end
            if (!stop && (op_reg == OP_ALLOC) && sum_reg.alloc
                && (!sum_reg.a_nf || !sum_reg.a_nr))
            begin
                res_next[n] = '{code: W_ALLOC_LIVE, fatal: 1'b1, from_leak: 1'b0};
                n = n + 2'd1;
                stop = 1'b1;
            end
        end
        res_cnt_next = n;
        any_fatal = stop;
    end

    assign cur_res  = res_reg[ptr_reg];
    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        halted_next    = halted_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // drop events outright once halted
                if (accept && !halted_reg)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                if (!full)
                begin
                    count_next = count_reg + CW'(1);
                end
                if (any_fatal)
                begin
                    halted_next = 1'b1;
                end
                ptr_next = 2'd0;
                if (res_cnt_next == 2'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    ptr_next = ptr_reg + 2'd1;
                    if (ptr_reg == res_cnt_reg - 2'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            halted_reg    <= 1'b0;
            count_reg     <= '0;
            en_reg        <= 1'b1;
            ptr_reg       <= 2'd0;
            res_cnt_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            halted_reg    <= halted_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                en_reg <= check_enable;
            end
            if (state_reg == ST_DEC)
            begin
                res_cnt_reg <= res_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= address[AW-1:0];
            kind_reg <= alloc_kind;
            op_reg   <= operation;
        end
        if (state_reg == ST_RED)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == ST_DEC)
        begin
            res_reg       <= res_next;
            leak_addr_reg <= oldest_addr;
        end
        if (load_out)
        begin
            out_code_reg  <= cur_res.code;
            out_fatal_reg <= cur_res.fatal;
            out_addr_reg  <= cur_res.from_leak ? leak_addr_reg : addr_reg;
            out_last_reg  <= (ptr_reg == res_cnt_reg - 2'd1);
        end
    end

    assign out_valid     = out_valid_reg;
    assign warning_code  = out_code_reg;
    assign fatal         = out_fatal_reg;
    assign entry_address = FIELD_AW'(out_addr_reg);
    assign last_result   = out_last_reg;

`ifndef SYNTHESIS
    logic [N-1:0] alloc_vec;
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            alloc_vec[i] = hits[i].alloc;
        end
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_fatal_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fatal_reg) |-> halted_reg)
        else $error("fatal warning shown while not halted");

    a_fatal_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fatal_reg) |-> out_last_reg)
        else $error("fatal warning is not the final beat");

    a_one_newest_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RED) |-> $onehot0(alloc_vec))
        else $error("more than one cell claims the newest alloc");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("fill count beyond history size");
`endif

endmodule

FILE: src/allocation_history_checker.sv
// Top level of the allocation history checker: a row of history cells and
// the sequencer. Uses ahc_pkg, ahc_cell and ahc_ctrl.
//
// Each accepted event beat runs compare, reduce and decide over the whole
// cell row. The in_ready output drops at acceptance and comes back once the
// event is recorded and, for an event that raises k warnings (k at most 3),
// once its warnings are issued at one output beat per cycle while out_ready
// stays high. Each event passes through the registered compare in every
// cell, the OR reduction of the cell summaries and the shift that records
// the event. The history holds HISTORY_DEPTH-1 events, newest at cell 0;
// when it is full the oldest is checked for a leak and shifted out, and it
// takes no part in the search for the new event. Once a fatal warning is
// given, later events are accepted one per cycle and dropped until reset.
// No clearing pass runs after reset; the fill count marks which cells hold
// events.
module allocation_history_checker #(
    parameter int HISTORY_DEPTH = 64,
    parameter int ADDR_WIDTH    = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ahc_pkg::FIELD_AW-1:0] address,
    input  logic                         alloc_kind,
    input  logic [1:0]                   operation,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         check_enable,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   warning_code,
    output logic                         fatal,
    output logic [ahc_pkg::FIELD_AW-1:0] entry_address,
    output logic                         last_result
);
    import ahc_pkg::*;

    localparam int N  = HISTORY_DEPTH - 1;
    localparam int CW = $clog2(N + 1);
    localparam int AW = (ADDR_WIDTH < FIELD_AW) ? ADDR_WIDTH : FIELD_AW;

    cell_ctl_t         ctl;
    logic [AW-1:0]     new_addr;
    logic [CW-1:0]     count;
    hit_t [N-1:0]      hits;
    logic [AW-1:0]     cell_addr [N];
    entry_t            cell_entry [N];
    entry_t            cell_fwd [N-1];
    entry_t            head_entry;

    always_comb
    begin
        head_entry.op   = ctl.op;
        head_entry.kind = ctl.kind;
        head_entry.na   = 1'b0;
        head_entry.nf   = 1'b0;
        head_entry.nr   = 1'b0;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic          valid_i;
        logic [AW-1:0] prev_addr_i;
        entry_t        prev_entry_i;

        // the last cell only fills when the history is full, and its entry
        // takes no part in the search for the new event
        assign valid_i = (i == N - 1) ? 1'b0 : (count > CW'(i));

        if (i == 0)
        begin : g_head
            assign prev_addr_i  = new_addr;
            assign prev_entry_i = head_entry;
        end
        else
        begin : g_body
            assign prev_addr_i  = cell_addr[i-1];
            assign prev_entry_i = cell_fwd[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            ahc_cell #(.AW(AW)) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_addr   (new_addr),
                .cell_valid (valid_i),
                .prev_addr  (prev_addr_i),
                .prev_entry (prev_entry_i),
                .addr       (cell_addr[i]),
                .entry      (cell_entry[i]),
                .fwd_entry  (),
                .hit        (hits[i])
            );
        end
        else
        begin : g_mid
            ahc_cell #(.AW(AW)) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_addr   (new_addr),
                .cell_valid (valid_i),
                .prev_addr  (prev_addr_i),
                .prev_entry (prev_entry_i),
                .addr       (cell_addr[i]),
                .entry      (cell_entry[i]),
                .fwd_entry  (cell_fwd[i]),
                .hit        (hits[i])
            );
        end
    end

    ahc_ctrl #(
        .AW (AW),
        .N  (N),
        .CW (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .address       (address),
        .alloc_kind    (alloc_kind),
        .operation     (operation),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .check_enable  (check_enable),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .warning_code  (warning_code),
        .fatal         (fatal),
        .entry_address (entry_address),
        .last_result   (last_result),
        .ctl           (ctl),
        .new_addr      (new_addr),
        .count         (count),
        .hits          (hits),
        .oldest_entry  (cell_entry[N-1]),
        .oldest_addr   (cell_addr[N-1])
    );

endmodule
